### sv/jdcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_pkg
// Shared types and constants for the joystick dot cursor mover.
// ----------------------------------------------------------------------------
package jdcm_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int DOT_W      = 8;
    localparam int INTERVAL_W = 5;
    localparam int TICK_W     = 8;
    localparam int RES20_W    = 5;

    localparam logic [SAMPLE_W-1:0] DEAD_LOW  = 10'd500;
    localparam logic [SAMPLE_W-1:0] DEAD_HIGH = 10'd600;
    localparam logic [SAMPLE_W-1:0] HIGH_1    = 10'd700;
    localparam logic [SAMPLE_W-1:0] HIGH_2    = 10'd800;
    localparam logic [SAMPLE_W-1:0] HIGH_3    = 10'd900;
    localparam logic [SAMPLE_W-1:0] LOW_1     = 10'd400;
    localparam logic [SAMPLE_W-1:0] LOW_2     = 10'd300;
    localparam logic [SAMPLE_W-1:0] LOW_3     = 10'd200;

    localparam logic [DOT_W-1:0] COL_LEFT   = 8'h80;
    localparam logic [DOT_W-1:0] COL_RIGHT  = 8'h01;
    localparam logic [DOT_W-1:0] ROW_TOP    = 8'hFE;
    localparam logic [DOT_W-1:0] ROW_BOTTOM = 8'hEF;

    localparam logic [INTERVAL_W-1:0] IVL_SLOW    = 5'd20;
    localparam logic [INTERVAL_W-1:0] IVL_MEDIUM  = 5'd10;
    localparam logic [INTERVAL_W-1:0] IVL_FAST    = 5'd5;
    localparam logic [INTERVAL_W-1:0] IVL_FASTEST = 5'd2;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_IDLE  = 2'd1,
        MODE_MOVE  = 2'd2
    } mode_t;

    typedef enum logic {
        CTRL_WAIT   = 1'b0,
        CTRL_UPDATE = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } dp_cmd_t;

endpackage

### sv/jdcm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_datapath
// Sample capture, step intervals, mode register, tick gating and dot position.
// ----------------------------------------------------------------------------
module jdcm_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  jdcm_pkg::dp_cmd_t                cmd,
    input  logic [jdcm_pkg::SAMPLE_W-1:0]    x_sample,
    input  logic [jdcm_pkg::SAMPLE_W-1:0]    y_sample,
    output logic [jdcm_pkg::DOT_W-1:0]       column_pattern,
    output logic [jdcm_pkg::DOT_W-1:0]       row_drive
);

    logic [jdcm_pkg::SAMPLE_W-1:0]   x_reg, y_reg;
    jdcm_pkg::mode_t                 mode_reg, mode_next;
    logic [jdcm_pkg::TICK_W-1:0]     tick_reg, tick_next, tick_eff;
    logic [jdcm_pkg::RES20_W-1:0]    res20_reg, res20_next, res20_eff;
    logic [jdcm_pkg::RES20_W-1:0]    res10, res5;
    logic [jdcm_pkg::DOT_W-1:0]      col_reg, col_next, col_base;
    logic [jdcm_pkg::DOT_W-1:0]      row_reg, row_next, row_base;
    logic [jdcm_pkg::INTERVAL_W-1:0] x_ivl_reg, x_ivl_next;
    logic [jdcm_pkg::INTERVAL_W-1:0] y_ivl_reg, y_ivl_next;
    logic x_pos, x_neg, y_pos, y_neg, centred;
    logic clear_tick, act, gate_x, gate_y;

    function automatic logic [jdcm_pkg::INTERVAL_W-1:0] interval_for(
        input logic [jdcm_pkg::SAMPLE_W-1:0]   s,
        input logic [jdcm_pkg::INTERVAL_W-1:0] old
    );
        logic [jdcm_pkg::INTERVAL_W-1:0] r;
        priority if ((s > jdcm_pkg::DEAD_HIGH && s <= jdcm_pkg::HIGH_1) ||
                     (s < jdcm_pkg::DEAD_LOW && s >= jdcm_pkg::LOW_1))
            r = jdcm_pkg::IVL_SLOW;
        else if ((s > jdcm_pkg::HIGH_1 && s <= jdcm_pkg::HIGH_2) ||
                 (s < jdcm_pkg::LOW_1 && s >= jdcm_pkg::LOW_2))
            r = jdcm_pkg::IVL_MEDIUM;
        else if ((s > jdcm_pkg::HIGH_2 && s <= jdcm_pkg::HIGH_3) ||
                 (s < jdcm_pkg::LOW_2 && s >= jdcm_pkg::LOW_3))
            r = jdcm_pkg::IVL_FAST;
        else if (s > jdcm_pkg::HIGH_3 || s < jdcm_pkg::LOW_3)
            r = jdcm_pkg::IVL_FASTEST;
        else
            r = old;
        return r;
    endfunction

    function automatic logic residue_zero(
        input logic [jdcm_pkg::INTERVAL_W-1:0] ivl,
        input logic [jdcm_pkg::RES20_W-1:0]    r20,
        input logic [jdcm_pkg::RES20_W-1:0]    r10,
        input logic [jdcm_pkg::RES20_W-1:0]    r5,
        input logic                            r2
    );
        logic z;
        unique case (ivl)
            jdcm_pkg::IVL_SLOW:    z = (r20 == '0);
            jdcm_pkg::IVL_MEDIUM:  z = (r10 == '0);
            jdcm_pkg::IVL_FAST:    z = (r5 == '0);
            jdcm_pkg::IVL_FASTEST: z = !r2;
            default:               z = (r20 == '0);
        endcase
        return z;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= x_sample;
            y_reg <= y_sample;
        end
    end

    always_comb
    begin
        x_pos   = (x_reg > jdcm_pkg::DEAD_HIGH);
        x_neg   = (x_reg < jdcm_pkg::DEAD_LOW);
        y_pos   = (y_reg > jdcm_pkg::DEAD_HIGH);
        y_neg   = (y_reg < jdcm_pkg::DEAD_LOW);
        centred = !(x_pos || x_neg || y_pos || y_neg);

        x_ivl_next = interval_for(x_reg, x_ivl_reg);
        y_ivl_next = interval_for(y_reg, y_ivl_reg);

        mode_next  = mode_reg;
        clear_tick = 1'b0;
        act        = 1'b0;
        col_base   = col_reg;
        row_base   = row_reg;
        unique case (mode_reg)
            jdcm_pkg::MODE_START:
            begin
                mode_next  = jdcm_pkg::MODE_IDLE;
                clear_tick = 1'b1;
                col_base   = jdcm_pkg::COL_LEFT;
                row_base   = jdcm_pkg::ROW_TOP;
            end
            jdcm_pkg::MODE_IDLE:
            begin
                if (!centred)
                begin
                    mode_next  = jdcm_pkg::MODE_MOVE;
                    clear_tick = 1'b1;
                    act        = 1'b1;
                end
            end
            jdcm_pkg::MODE_MOVE:
            begin
                if (centred)
                    mode_next = jdcm_pkg::MODE_IDLE;
                else
                    act = 1'b1;
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        tick_eff  = clear_tick ? '0 : tick_reg;
        res20_eff = clear_tick ? '0 : res20_reg;
        res10     = (res20_eff >= 5'd10) ? res20_eff - 5'd10 : res20_eff;
        res5      = (res10 >= 5'd5) ? res10 - 5'd5 : res10;

        gate_x = residue_zero(x_ivl_next, res20_eff, res10, res5, tick_eff[0]);
        gate_y = residue_zero(y_ivl_next, res20_eff, res10, res5, tick_eff[0])
                 && (y_pos || y_neg);

        col_next   = col_base;
        row_next   = row_base;
        tick_next  = tick_eff;
        res20_next = res20_eff;
        if (act)
        begin
            if (gate_x || gate_y)
            begin
                if (x_pos && col_base != jdcm_pkg::COL_RIGHT)
                    col_next = {1'b0, col_base[jdcm_pkg::DOT_W-1:1]};
                else if (x_neg && col_base != jdcm_pkg::COL_LEFT)
                    col_next = {col_base[jdcm_pkg::DOT_W-2:0], 1'b0};
                if (y_pos && row_base != jdcm_pkg::ROW_TOP)
                    row_next = {1'b1, row_base[jdcm_pkg::DOT_W-1:1]};
                else if (y_neg && row_base != jdcm_pkg::ROW_BOTTOM)
                    row_next = {row_base[jdcm_pkg::DOT_W-2:0], 1'b1};
            end
            tick_next = tick_eff + 8'd1;
            if (tick_eff == '1 || res20_eff == 5'd19)
                res20_next = '0;
            else
                res20_next = res20_eff + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= jdcm_pkg::MODE_START;
            tick_reg  <= '0;
            res20_reg <= '0;
            col_reg   <= jdcm_pkg::COL_LEFT;
            row_reg   <= jdcm_pkg::ROW_TOP;
            x_ivl_reg <= jdcm_pkg::IVL_SLOW;
            y_ivl_reg <= jdcm_pkg::IVL_SLOW;
        end
        else if (cmd.commit)
        begin
            mode_reg  <= mode_next;
            tick_reg  <= tick_next;
            res20_reg <= res20_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            x_ivl_reg <= x_ivl_next;
            y_ivl_reg <= y_ivl_next;
        end
    end

    assign column_pattern = col_reg;
    assign row_drive      = row_reg;

`ifndef SYNTHESIS
    a_col_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(col_reg))
        else $error("column pattern not one-hot");
    a_row_one_low: assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg[7:5] == 3'b111) && ($countones(row_reg[4:0]) == 4))
        else $error("row drive not a single active row");
    a_res_track: assert property (@(posedge clk) disable iff (!rst_n)
        res20_reg < 5'd20)
        else $error("mod-20 residue out of range");
`endif

endmodule

### sv/jdcm_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcm_controller
// Request handshake sequencer and output valid flag.
// ----------------------------------------------------------------------------
module jdcm_controller
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output jdcm_pkg::dp_cmd_t cmd
);

    jdcm_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jdcm_pkg::CTRL_WAIT:
            begin
                if (in_valid)
                    state_next = jdcm_pkg::CTRL_UPDATE;
            end
            jdcm_pkg::CTRL_UPDATE:
            begin
                if (slot_free)
                    state_next = jdcm_pkg::CTRL_WAIT;
            end
            default:
            begin
                state_next = jdcm_pkg::CTRL_WAIT;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            jdcm_pkg::CTRL_WAIT:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            jdcm_pkg::CTRL_UPDATE:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        out_valid_next = cmd.commit ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jdcm_pkg::CTRL_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_rise_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result raised without a commit");
    a_load_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == jdcm_pkg::CTRL_UPDATE)
        else $error("load not followed by update");
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && !$past(cmd.commit))
        else $error("stalled result dropped or overwritten");
`endif

endmodule

### sv/joystick_dot_cursor_mover_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_dot_cursor_mover_core
// Moves a dot on an 8x5 matrix from joystick samples, one request per tick.
// ----------------------------------------------------------------------------
// A request is captured on accept and committed in the update state; a new
// request is not taken before then, and the update waits while a result is
// still held in the output register and not taken.
// Reset: asynchronous active low; mode start, tick 0, dot at column 0x80,
// row 0xFE, both intervals 20, no result pending.
module joystick_dot_cursor_mover_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [jdcm_pkg::SAMPLE_W-1:0] x_sample,
    input  logic [jdcm_pkg::SAMPLE_W-1:0] y_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [jdcm_pkg::DOT_W-1:0]    column_pattern,
    output logic [jdcm_pkg::DOT_W-1:0]    row_drive
);

    jdcm_pkg::dp_cmd_t cmd;

    jdcm_controller u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    jdcm_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .x_sample       (x_sample),
        .y_sample       (y_sample),
        .column_pattern (column_pattern),
        .row_drive      (row_drive)
    );

endmodule

### test/joystick_dot_cursor_mover_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_dot_cursor_mover_core_tb
// Drives joystick sample pairs into the cursor mover with bursty requests and
// a stalling receiver, tracks the expected dot position per request and checks
// every returned column/row pair in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] column;
    logic [7:0] row;
} dot_pos_t;

class dot_tracker;
    jdcm_pkg::mode_t mode     = jdcm_pkg::MODE_START;
    logic [7:0]      ticks    = 8'd0;
    logic [7:0]      column   = jdcm_pkg::COL_LEFT;
    logic [7:0]      row      = jdcm_pkg::ROW_TOP;
    logic [4:0]      x_period = jdcm_pkg::IVL_SLOW;
    logic [4:0]      y_period = jdcm_pkg::IVL_SLOW;
    dot_pos_t        pending_dots[$];
    int              errors   = 0;

    function logic [4:0] period_for(logic [9:0] s, logic [4:0] old);
        if ((s > 10'd600 && s <= 10'd700) || (s < 10'd500 && s >= 10'd400))
            return jdcm_pkg::IVL_SLOW;
        if ((s > 10'd700 && s <= 10'd800) || (s < 10'd400 && s >= 10'd300))
            return jdcm_pkg::IVL_MEDIUM;
        if ((s > 10'd800 && s <= 10'd900) || (s < 10'd300 && s >= 10'd200))
            return jdcm_pkg::IVL_FAST;
        if (s > 10'd900 || s < 10'd200)
            return jdcm_pkg::IVL_FASTEST;
        return old;
    endfunction

    function int lean_of(logic [9:0] s);
        if (s > jdcm_pkg::DEAD_HIGH)
            return 1;
        if (s < jdcm_pkg::DEAD_LOW)
            return -1;
        return 0;
    endfunction

    function void shift_dot(int dx, int dy);
        if (dx > 0 && column != jdcm_pkg::COL_RIGHT)
            column = column >> 1;
        else if (dx < 0 && column != jdcm_pkg::COL_LEFT)
            column = column << 1;
        if (dy > 0 && row != jdcm_pkg::ROW_TOP)
            row = {1'b1, row[7:1]};
        else if (dy < 0 && row != jdcm_pkg::ROW_BOTTOM)
            row = {row[6:0], 1'b1};
    endfunction

    function void take_request(logic [9:0] xs, logic [9:0] ys);
        int dx;
        int dy;
        dot_pos_t pos;
        dx = lean_of(xs);
        dy = lean_of(ys);
        x_period = period_for(xs, x_period);
        y_period = period_for(ys, y_period);
        case (mode)
            jdcm_pkg::MODE_START:
            begin
                mode   = jdcm_pkg::MODE_IDLE;
                column = jdcm_pkg::COL_LEFT;
                row    = jdcm_pkg::ROW_TOP;
                ticks  = 8'd0;
            end
            jdcm_pkg::MODE_IDLE:
            begin
                if (dx != 0 || dy != 0)
                begin
                    ticks = 8'd0;
                    mode  = jdcm_pkg::MODE_MOVE;
                end
            end
            jdcm_pkg::MODE_MOVE:
            begin
                if (dx == 0 && dy == 0)
                    mode = jdcm_pkg::MODE_IDLE;
            end
            default: ;
        endcase
        if (mode == jdcm_pkg::MODE_MOVE)
        begin
            if (int'(ticks) % int'(x_period) == 0)
                shift_dot(dx, dy);
            else if (int'(ticks) % int'(y_period) == 0 && dy != 0)
                shift_dot(dx, dy);
            ticks = ticks + 8'd1;
        end
        pos.column = column;
        pos.row    = row;
        pending_dots.push_back(pos);
    endfunction

    function void match_dot(logic [7:0] col_seen, logic [7:0] row_seen);
        dot_pos_t want;
        if (pending_dots.size() == 0)
        begin
            $display("%0t: unexpected result column_pattern %h row_drive %h",
                     $time, col_seen, row_seen);
            errors++;
            return;
        end
        want = pending_dots.pop_front();
        if (col_seen !== want.column)
        begin
            $display("%0t: column_pattern expected %h actual %h",
                     $time, want.column, col_seen);
            errors++;
        end
        if (row_seen !== want.row)
        begin
            $display("%0t: row_drive expected %h actual %h", $time, want.row, row_seen);
            errors++;
        end
    endfunction
endclass

module joystick_dot_cursor_mover_core_tb;

    localparam int ITEM_COUNT  = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [jdcm_pkg::SAMPLE_W-1:0] x_sample;
    logic [jdcm_pkg::SAMPLE_W-1:0] y_sample;
    logic                          out_valid;
    logic                          out_ready;
    logic [jdcm_pkg::DOT_W-1:0]    column_pattern;
    logic [jdcm_pkg::DOT_W-1:0]    row_drive;

    dot_tracker tracker;
    int         cycles;
    int         sent;
    int         burst_left;
    bit         steady;
    bit         hold_request;

    joystick_dot_cursor_mover_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .x_sample       (x_sample),
        .y_sample       (y_sample),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .column_pattern (column_pattern),
        .row_drive      (row_drive)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic send_request(logic [9:0] xs, logic [9:0] ys);
        in_valid <= 1'b1;
        x_sample <= xs;
        y_sample <= ys;
        do
            @(posedge clk);
        while (!in_ready);
        tracker.take_request(xs, ys);
        sent++;
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_paced(logic [9:0] xs, logic [9:0] ys);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!steady)
                idle_for($urandom_range(0, 8));
        end
        burst_left--;
        send_request(xs, ys);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_dots.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [9:0] pick_sample(int lean, int level);
        int lo;
        int hi;
        if (lean == 0)
        begin
            lo = 500;
            hi = 600;
        end
        else if (lean > 0)
        begin
            lo = 601 + 100 * level;
            hi = (level == 3) ? 1023 : 700 + 100 * level;
        end
        else
        begin
            lo = (level == 3) ? 0 : 400 - 100 * level;
            hi = 499 - 100 * level;
        end
        return 10'($urandom_range(lo, hi));
    endfunction

    // receiver: stall in changing styles, honor long hold-off requests
    initial
    begin
        int style;
        int left;
        int hold;
        int phase;
        style = 0;
        left  = 0;
        hold  = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                tracker.match_dot(column_pattern, row_drive);
            if (hold_request && hold == 0)
            begin
                hold = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (left == 0)
            begin
                style = $urandom_range(0, 3);
                left  = $urandom_range(16, 96);
            end
            left--;
            phase++;
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) < 7);
                    2:       out_ready <= (phase % 3 != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        int run;
        int runs;
        int x_lean;
        int y_lean;
        int x_level;
        int y_level;
        logic [9:0] xs;
        logic [9:0] ys;
        tracker      = new;
        sent         = 0;
        burst_left   = 0;
        steady       = 1'b0;
        hold_request = 1'b0;
        rst_n        = 1'b0;
        in_valid     <= 1'b0;
        x_sample     <= '0;
        y_sample     <= '0;
        out_ready    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_paced(10'd550, 10'd550);
        send_paced(10'd500, 10'd600);
        send_paced(10'd0, 10'd1023);
        send_paced(10'd1023, 10'd0);
        send_paced(10'd1023, 10'd0);
        send_paced(10'd901, 10'd550);
        send_paced(10'd900, 10'd550);
        send_paced(10'd801, 10'd499);
        send_paced(10'd800, 10'd400);
        send_paced(10'd701, 10'd399);
        send_paced(10'd700, 10'd300);
        send_paced(10'd601, 10'd299);
        send_paced(10'd499, 10'd200);
        send_paced(10'd400, 10'd199);
        send_paced(10'd399, 10'd901);
        send_paced(10'd300, 10'd900);
        send_paced(10'd299, 10'd801);
        send_paced(10'd200, 10'd800);
        send_paced(10'd199, 10'd701);
        send_paced(10'd550, 10'd550);
        send_paced(10'd601, 10'd550);
        send_paced(10'd550, 10'd0);
        send_paced(10'd550, 10'd1023);
        send_paced(10'd1023, 10'd1023);
        send_paced(10'd0, 10'd0);

        // hold the stick in one direction per run, with some noise
        runs = 0;
        while (sent < ITEM_COUNT)
        begin
            run     = $urandom_range(1, 40);
            x_lean  = int'($urandom_range(0, 2)) - 1;
            y_lean  = int'($urandom_range(0, 2)) - 1;
            x_level = $urandom_range(0, 3);
            y_level = $urandom_range(0, 3);
            steady  = ($urandom_range(0, 3) == 0);
            if (runs % 17 == 8)
                wait_drained();
            if (runs % 12 == 5)
            begin
                hold_request = 1'b1;
                steady = 1'b1;
                run = 40;
            end
            runs++;
            for (int i = 0; i < run; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    xs = 10'($urandom_range(0, 1023));
                    ys = 10'($urandom_range(0, 1023));
                end
                else
                begin
                    xs = pick_sample(x_lean, x_level);
                    ys = pick_sample(y_lean, y_level);
                end
                send_paced(xs, ys);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_dots.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (tracker.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
